@@ design/gmn_pkg.sv @@
`default_nettype none
package gmn_pkg;

   // item opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   // configuration register indexes
   localparam logic CSR_SAMPLE_TYPE = 1'b0;
   localparam logic CSR_BIG_ENDIAN  = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] GRAY_FLAT    = 8'h7F;

   // classified item passed from front to back
   typedef struct packed {
      logic        op;
      logic [63:0] value;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCALE,
      ST_DIV,
      ST_OUT
   } back_state_type;

endpackage
`default_nettype wire

@@ design/gray_minmax_normalize_to_rgba.sv @@
// Min/max contrast stretch of a grayscale frame to RGBA. Loads are decoded
// (width, byte order, sign bias) on entry and queued in a two-entry queue;
// the back end stores up to FRAME_PIXELS of them, tracking min/max, one
// per cycle unless a frame is being emitted. An emit runs a frame-store
// read, difference, scaling by 255 and an 8-step restoring divide (skipped
// for a flat frame) before its one-cycle rsp_valid strobe. busy is high
// while the queue is full; results cannot be stalled by the receiver.
`default_nettype none
module gray_minmax_normalize_to_rgba #(
   parameter int FRAME_PIXELS = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [63:0] req_sample,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [2:0]  csr_wdata,
   output logic             rsp_valid,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic             rsp_last_pixel
);

   gmn_pkg::item_type front_item, queue_item;
   logic accept, pop, empty, full;
   logic [7:0] gray;

   assign accept    = start && !busy;
   assign busy      = full;
   assign csr_ready = 1'b1;

   gmn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .req_op     (req_op),
      .req_sample (req_sample),
      .item       (front_item)
   );

   gmn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (pop),
      .pop_item  (queue_item),
      .empty     (empty),
      .full      (full)
   );

   gmn_back #(.FRAME_PIXELS(FRAME_PIXELS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .item       (queue_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .gray       (gray),
      .last_pixel (rsp_last_pixel)
   );

   assign rsp_red   = gray;
   assign rsp_green = gray;
   assign rsp_blue  = gray;
   assign rsp_alpha = gmn_pkg::ALPHA_OPAQUE;

endmodule
`default_nettype wire

@@ design/gmn_front.sv @@
`default_nettype none
module gmn_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic              csr_index,
   input  wire logic [2:0]        csr_wdata,
   input  wire logic              accept,
   input  wire logic              req_op,
   input  wire logic [63:0]       req_sample,
   output gmn_pkg::item_type      item
);

   logic [2:0] sample_type_ff;
   logic       big_endian_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_type_ff <= 3'd0;
         big_endian_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            gmn_pkg::CSR_SAMPLE_TYPE: sample_type_ff <= csr_wdata;
            gmn_pkg::CSR_BIG_ENDIAN:  big_endian_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [63:0] masked;
   logic [63:0] swapped;
   logic [63:0] biased;

   // mask to sample width, optional byte swap, sign bias
   always_comb begin
      masked  = req_sample;
      swapped = 64'd0;
      biased  = 64'd0;
      case (sample_type_ff[2:1])
         2'd0: begin
            masked  = {56'd0, req_sample[7:0]};
            swapped = masked;
            biased  = swapped ^ 64'h80;
         end
         2'd1: begin
            masked  = {48'd0, req_sample[15:0]};
            swapped = {48'd0, masked[7:0], masked[15:8]};
            biased  = (big_endian_ff ? swapped : masked) ^ 64'h8000;
         end
         2'd2: begin
            masked  = {32'd0, req_sample[31:0]};
            swapped = {32'd0, masked[7:0], masked[15:8], masked[23:16], masked[31:24]};
            biased  = (big_endian_ff ? swapped : masked) ^ 64'h8000_0000;
         end
         default: begin
            masked  = req_sample;
            swapped = {masked[7:0], masked[15:8], masked[23:16], masked[31:24],
                       masked[39:32], masked[47:40], masked[55:48], masked[63:56]};
            biased  = (big_endian_ff ? swapped : masked) ^ 64'h8000_0000_0000_0000;
         end
      endcase
      item.op    = req_op;
      if (sample_type_ff[0])
         item.value = biased;
      else if (big_endian_ff)
         item.value = swapped;
      else
         item.value = masked;
      if (!accept)
         item.op = req_op;
   end

endmodule
`default_nettype wire

@@ design/gmn_queue.sv @@
`default_nettype none
module gmn_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gmn_pkg::item_type push_item,
   input  wire logic              pop,
   output gmn_pkg::item_type      pop_item,
   output logic                   empty,
   output logic                   full
);

   gmn_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   // two-entry item queue
   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign pop_item = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);

endmodule
`default_nettype wire

@@ design/gmn_back.sv @@
`default_nettype none
module gmn_back #(
   parameter int FRAME_PIXELS = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              empty,
   input  wire gmn_pkg::item_type item,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [7:0]             gray,
   output logic                   last_pixel
);

   localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
   localparam int CW = $clog2(FRAME_PIXELS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(FRAME_PIXELS);

   logic [63:0] mem [FRAME_PIXELS];
   logic [63:0] rd_data_ff;

   gmn_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] index_ff, index_in;
   logic [63:0]   min_ff, min_in, max_ff, max_in;
   logic          emitting_ff, emitting_in;
   logic          last_ff, last_in;
   logic          flat_ff, flat_in;
   logic [63:0]   d_ff, d_in, r_ff, r_in;
   logic [71:0]   rem_ff, rem_in;
   logic [7:0]    quo_ff, quo_in;
   logic [2:0]    bit_ff, bit_in;
   logic          wr_en;
   logic [72:0]   trial;
   logic [63:0]   diff;

   // frame store
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[count_ff[AW-1:0]] <= item.value;
      rd_data_ff <= mem[index_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= gmn_pkg::ST_IDLE;
         count_ff    <= '0;
         index_ff    <= '0;
         min_ff      <= '1;
         max_ff      <= '0;
         emitting_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         index_ff    <= index_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         emitting_ff <= emitting_in;
      end
      last_ff <= last_in;
      flat_ff <= flat_in;
      d_ff    <= d_in;
      r_ff    <= r_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      bit_ff  <= bit_in;
   end

   assign trial = {1'b0, rem_ff} - ({8'd0, r_ff} << bit_ff);
   assign diff  = (rd_data_ff > min_ff) ? rd_data_ff - min_ff : 64'd0;

   // sequencer: load, then read / scale / divide / deliver for emit
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      index_in    = index_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      emitting_in = emitting_ff;
      last_in     = last_ff;
      flat_in     = flat_ff;
      d_in        = d_ff;
      r_in        = r_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      bit_in      = bit_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      case (state_ff)
         gmn_pkg::ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (item.op == gmn_pkg::OP_LOAD) begin
                  if (!emitting_ff && count_ff < FULL_COUNT) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (item.value < min_ff) min_in = item.value;
                     if (item.value > max_ff) max_in = item.value;
                  end
               end else if (count_ff != '0 && index_ff < count_ff) begin
                  emitting_in = 1'b1;
                  last_in     = (index_ff + 1'b1 == count_ff);
                  state_in    = gmn_pkg::ST_READ;
               end
            end
         end
         gmn_pkg::ST_READ: begin
            flat_in  = !(max_ff > min_ff);
            r_in     = max_ff - min_ff;
            d_in     = diff;
            state_in = gmn_pkg::ST_SCALE;
         end
         gmn_pkg::ST_SCALE: begin
            // 255*d, with d clamped to the range
            rem_in   = {((d_ff > r_ff) ? r_ff : d_ff), 8'd0}
                     - {8'd0, ((d_ff > r_ff) ? r_ff : d_ff)};
            bit_in   = 3'd7;
            quo_in   = flat_ff ? gmn_pkg::GRAY_FLAT : 8'd0;
            state_in = flat_ff ? gmn_pkg::ST_OUT : gmn_pkg::ST_DIV;
         end
         gmn_pkg::ST_DIV: begin
            // one quotient bit per cycle
            if (!trial[72]) begin
               rem_in         = trial[71:0];
               quo_in[bit_ff] = 1'b1;
            end
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0)
               state_in = gmn_pkg::ST_OUT;
         end
         gmn_pkg::ST_OUT: begin
            state_in = gmn_pkg::ST_IDLE;
            if (last_ff) begin
               count_in    = '0;
               index_in    = '0;
               min_in      = '1;
               max_in      = '0;
               emitting_in = 1'b0;
            end else begin
               index_in = index_ff + 1'b1;
            end
         end
         default: state_in = gmn_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid  = (state_ff == gmn_pkg::ST_OUT);
   assign gray       = quo_ff;
   assign last_pixel = last_ff;

endmodule
`default_nettype wire
